FILE: src/lvlm_pkg.sv
// Shared types and constants for the windowed RMS/peak level meter.
`default_nettype none
package lvlm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int WINDOW_MAX  = 4096;
  localparam int LEN_W       = 13;
  localparam int LEN_RESET   = 1024;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W       = 43;
  localparam int LEVEL_W     = 16;
  localparam int ROOT_W      = (SUM_W + 1) / 2;
  localparam int WORK_W      = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 3;
  localparam int DIV_STEPS   = SUM_W;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic [0:0] {
    CFG_MODE   = 1'b0,
    CFG_WINDOW = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    MODE_RMS  = 1'b0,
    MODE_PEAK = 1'b1
  } meter_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV,
    ST_SQLOAD,
    ST_SQRT,
    ST_HOLD,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic square;
    logic accum;
    logic load_div;
    logic step_div;
    logic load_sqrt;
    logic step_sqrt;
    logic hold_root;
    logic emit;
  } ctl_t;

  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(WINDOW_MAX)) begin
      res = LEN_W'(WINDOW_MAX);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: src/lvlm_ctrl.sv
// Sequencer for the level meter: state machine and iteration step counter.
`default_nettype none
module lvlm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          window_done,
  input  wire logic          rms_sel,
  input  wire logic          out_free,
  output lvlm_pkg::ctl_t     ctl
);

  lvlm_pkg::state_t                 state_r, state_nxt;
  logic [lvlm_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                             div_last, sqrt_last;

  assign div_last  = (step_r == lvlm_pkg::STEP_W'(lvlm_pkg::DIV_STEPS - 1));
  assign sqrt_last = (step_r == lvlm_pkg::STEP_W'(lvlm_pkg::SQRT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lvlm_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      lvlm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lvlm_pkg::ST_SQUARE;
        end
      end
      lvlm_pkg::ST_SQUARE: begin
        state_nxt = lvlm_pkg::ST_ACCUM;
      end
      lvlm_pkg::ST_ACCUM: begin
        step_nxt = '0;
        if (window_done && rms_sel) begin
          state_nxt = lvlm_pkg::ST_DIV;
        end else begin
          state_nxt = lvlm_pkg::ST_OUTPUT;
        end
      end
      lvlm_pkg::ST_DIV: begin
        step_nxt = step_r + lvlm_pkg::STEP_W'(1);
        if (div_last) begin
          state_nxt = lvlm_pkg::ST_SQLOAD;
        end
      end
      lvlm_pkg::ST_SQLOAD: begin
        step_nxt  = '0;
        state_nxt = lvlm_pkg::ST_SQRT;
      end
      lvlm_pkg::ST_SQRT: begin
        step_nxt = step_r + lvlm_pkg::STEP_W'(1);
        if (sqrt_last) begin
          state_nxt = lvlm_pkg::ST_HOLD;
        end
      end
      lvlm_pkg::ST_HOLD: begin
        state_nxt = lvlm_pkg::ST_OUTPUT;
      end
      lvlm_pkg::ST_OUTPUT: begin
        if (out_free) begin
          state_nxt = lvlm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lvlm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.in_ready  = (state_r == lvlm_pkg::ST_IDLE);
    ctl.square    = (state_r == lvlm_pkg::ST_SQUARE);
    ctl.accum     = (state_r == lvlm_pkg::ST_ACCUM);
    ctl.load_div  = (state_r == lvlm_pkg::ST_ACCUM) && window_done && rms_sel;
    ctl.step_div  = (state_r == lvlm_pkg::ST_DIV);
    ctl.load_sqrt = (state_r == lvlm_pkg::ST_SQLOAD);
    ctl.step_sqrt = (state_r == lvlm_pkg::ST_SQRT);
    ctl.hold_root = (state_r == lvlm_pkg::ST_HOLD);
    ctl.emit      = (state_r == lvlm_pkg::ST_OUTPUT) && out_free;
  end

endmodule
`default_nettype wire

FILE: src/lvlm_iter.sv
// Shared compare-subtract unit with working registers for divide and square root.
`default_nettype none
module lvlm_iter (
  input  wire logic                          clk,
  input  wire lvlm_pkg::ctl_t                ctl,
  input  wire logic [lvlm_pkg::SUM_W-1:0]    sum_in,
  input  wire logic [lvlm_pkg::LEN_W-1:0]    divisor,
  output logic      [lvlm_pkg::ROOT_W-1:0]   root
);

  logic [lvlm_pkg::WORK_W-1:0] work_r;
  logic [lvlm_pkg::REM_W-1:0]  rem_r;
  logic [lvlm_pkg::ROOT_W-1:0] root_r;

  logic [lvlm_pkg::REM_W-1:0]  op_a, op_b, diff;
  logic                        ge;

  // one subtractor serves both the divide and the root steps
  always_comb begin
    if (ctl.step_sqrt) begin
      op_a = {rem_r[lvlm_pkg::REM_W-3:0], work_r[lvlm_pkg::WORK_W-1:lvlm_pkg::WORK_W-2]};
      op_b = {1'b0, root_r, 2'b01};
    end else begin
      op_a = lvlm_pkg::REM_W'({rem_r[lvlm_pkg::LEN_W-1:0], work_r[lvlm_pkg::SUM_W-1]});
      op_b = lvlm_pkg::REM_W'(divisor);
    end
  end

  assign diff = op_a - op_b;
  assign ge   = (op_a >= op_b);

  always_ff @(posedge clk) begin
    if (ctl.load_div) begin
      work_r <= lvlm_pkg::WORK_W'(sum_in);
      rem_r  <= '0;
    end else if (ctl.step_div) begin
      work_r <= {work_r[lvlm_pkg::WORK_W-2:0], ge};
      rem_r  <= ge ? diff : op_a;
    end else if (ctl.load_sqrt) begin
      work_r <= lvlm_pkg::WORK_W'(work_r[lvlm_pkg::SUM_W-1:0]);
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctl.step_sqrt) begin
      work_r <= {work_r[lvlm_pkg::WORK_W-3:0], 2'b00};
      rem_r  <= ge ? diff : op_a;
      root_r <= {root_r[lvlm_pkg::ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;

endmodule
`default_nettype wire

FILE: src/windowed_rms_peak_level_meter_top.sv
// Top level of the windowed RMS/peak level meter: accumulators, config and result register.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_sample
//   out_     output     out_valid / out_ready  out_level, out_level_new
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample that closes an RMS window also runs 43 restoring divide steps and
// 22 square-root steps, all through one shared subtractor.
// Synchronous active-low reset clears the state machine, accumulators and held level.
// The next sample is taken while a result waits in the output register; a new result
// waits in its final state until that register is free. cfg_ready is always high.
`default_nettype none
module windowed_rms_peak_level_meter_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [lvlm_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [lvlm_pkg::LEVEL_W-1:0]       out_level,
  output logic                                    out_level_new,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [0:0]                         cfg_index,
  input  wire logic [lvlm_pkg::LEN_W-1:0]         cfg_data
);

  lvlm_pkg::ctl_t                       ctl;
  logic                                 mode_r;
  logic [lvlm_pkg::LEN_W-1:0]           win_len_r;
  logic [lvlm_pkg::LEN_W-1:0]           count_r, count_inc, len_eff;
  logic [lvlm_pkg::SUM_W-1:0]           sum_r, sum_acc;
  logic [lvlm_pkg::SAMPLE_BITS-1:0]     peak_r, peak_acc, mag_r, raw, mag;
  logic [lvlm_pkg::SQ_W-1:0]            sq_r;
  logic [lvlm_pkg::LEVEL_W-1:0]         held_r;
  logic [lvlm_pkg::ROOT_W-1:0]          root;
  logic                                 fresh_r;
  logic                                 out_valid_r, out_new_r;
  logic [lvlm_pkg::LEVEL_W-1:0]         out_level_r;
  logic                                 window_done, out_free, rms_sel;

  assign raw       = in_sample;
  assign mag       = raw[lvlm_pkg::SAMPLE_BITS-1] ? (~raw + lvlm_pkg::SAMPLE_BITS'(1)) : raw;
  assign len_eff   = lvlm_pkg::eff_length(win_len_r);
  assign count_inc = count_r + lvlm_pkg::LEN_W'(1);
  assign window_done = (count_inc >= len_eff);
  assign sum_acc   = sum_r + lvlm_pkg::SUM_W'(sq_r);
  assign peak_acc  = (mag_r > peak_r) ? mag_r : peak_r;
  assign rms_sel   = (mode_r == lvlm_pkg::MODE_RMS);
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  lvlm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .window_done (window_done),
    .rms_sel     (rms_sel),
    .out_free    (out_free),
    .ctl         (ctl)
  );

  lvlm_iter u_iter (
    .clk     (clk),
    .ctl     (ctl),
    .sum_in  (sum_acc),
    .divisor (len_eff),
    .root    (root)
  );

  assign in_ready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lvlm_pkg::MODE_RMS;
      win_len_r   <= lvlm_pkg::LEN_W'(lvlm_pkg::LEN_RESET);
      count_r     <= '0;
      sum_r       <= '0;
      peak_r      <= '0;
      held_r      <= '0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lvlm_pkg::CFG_MODE:   mode_r    <= cfg_data[0];
          lvlm_pkg::CFG_WINDOW: win_len_r <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.accum) begin
        if (window_done) begin
          count_r <= '0;
          sum_r   <= '0;
          peak_r  <= '0;
          fresh_r <= 1'b1;
          if (!rms_sel) begin
            held_r <= peak_acc;
          end
        end else begin
          count_r <= count_inc;
          sum_r   <= sum_acc;
          peak_r  <= peak_acc;
          fresh_r <= 1'b0;
        end
      end
      if (ctl.hold_root) begin
        held_r <= root[lvlm_pkg::LEVEL_W-1:0];
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ctl.in_ready) begin
      mag_r <= mag;
    end
    if (ctl.square) begin
      sq_r <= lvlm_pkg::SQ_W'(mag_r) * lvlm_pkg::SQ_W'(mag_r);
    end
    if (ctl.emit) begin
      out_level_r <= held_r;
      out_new_r   <= fresh_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_level_new = out_new_r;

endmodule
`default_nettype wire

FILE: tb/windowed_rms_peak_level_meter_top_tb.sv
// Testbench for the windowed RMS/peak level meter: directed and random samples.
module windowed_rms_peak_level_meter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1300;
  localparam int CALM_ITEMS    = 200;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 3000;

  localparam logic signed [lvlm_pkg::SAMPLE_BITS-1:0] MOST_NEG = 16'h8000;
  localparam logic signed [lvlm_pkg::SAMPLE_BITS-1:0] MOST_POS = 16'h7FFF;

  typedef struct packed {
    logic [lvlm_pkg::LEVEL_W-1:0] level;
    logic                         fresh;
  } level_result_t;

  logic                                    clk = 1'b0;
  logic                                    rst_n = 1'b0;
  logic                                    in_valid = 1'b0;
  logic                                    in_ready;
  logic signed [lvlm_pkg::SAMPLE_BITS-1:0] in_sample = '0;
  logic                                    out_valid;
  logic                                    out_ready = 1'b0;
  logic [lvlm_pkg::LEVEL_W-1:0]            out_level;
  logic                                    out_level_new;
  logic                                    cfg_valid = 1'b0;
  logic                                    cfg_ready;
  lvlm_pkg::cfg_idx_t                      cfg_index = lvlm_pkg::CFG_MODE;
  logic [lvlm_pkg::LEN_W-1:0]              cfg_data = '0;

  lvlm_pkg::meter_mode_t        pred_mode = lvlm_pkg::MODE_RMS;
  logic [lvlm_pkg::LEN_W-1:0]   pred_window = lvlm_pkg::LEN_W'(lvlm_pkg::LEN_RESET);
  logic [lvlm_pkg::LEN_W-1:0]   pred_count = '0;
  logic [lvlm_pkg::SUM_W-1:0]   pred_sum = '0;
  logic [lvlm_pkg::LEVEL_W-1:0] pred_peak = '0;
  logic [lvlm_pkg::LEVEL_W-1:0] pred_held = '0;
  level_result_t                expected_levels[$];
  int                           mismatches = 0;
  int                           stall_cycles = 0;
  bit                           calm = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  windowed_rms_peak_level_meter_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_level    (out_level),
    .out_level_new(out_level_new),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic logic [lvlm_pkg::LEVEL_W-1:0] floor_root(
    input logic [lvlm_pkg::SUM_W-1:0] v
  );
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 4194303;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lvlm_pkg::LEVEL_W'(lo);
  endfunction

  function automatic void predict_level(input logic signed [lvlm_pkg::SAMPLE_BITS-1:0] s);
    longint                     mag;
    logic [lvlm_pkg::LEN_W-1:0] span;
    level_result_t              res;
    mag = (s < 0) ? -longint'(s) : longint'(s);
    pred_sum = pred_sum + lvlm_pkg::SUM_W'(mag * mag);
    if (mag > longint'(pred_peak)) begin
      pred_peak = lvlm_pkg::LEVEL_W'(mag);
    end
    pred_count = pred_count + lvlm_pkg::LEN_W'(1);
    if (pred_window == '0) begin
      span = lvlm_pkg::LEN_W'(1);
    end else if (pred_window > lvlm_pkg::LEN_W'(lvlm_pkg::WINDOW_MAX)) begin
      span = lvlm_pkg::LEN_W'(lvlm_pkg::WINDOW_MAX);
    end else begin
      span = pred_window;
    end
    res.fresh = 1'b0;
    if (pred_count >= span) begin
      if (pred_mode == lvlm_pkg::MODE_PEAK) begin
        pred_held = pred_peak;
      end else begin
        pred_held = floor_root(pred_sum / span);
      end
      pred_count = '0;
      pred_sum = '0;
      pred_peak = '0;
      res.fresh = 1'b1;
    end
    res.level = pred_held;
    expected_levels.push_back(res);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    level_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("result level %0d new %0b with no sample pending",
                                    out_level, out_level_new));
        end else begin
          want = expected_levels.pop_front();
          if (out_level !== want.level) begin
            report_mismatch($sformatf("level got %0d expected %0d", out_level, want.level));
          end
          if (out_level_new !== want.fresh) begin
            report_mismatch($sformatf("level_new got %0b expected %0b",
                                      out_level_new, want.fresh));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lvlm_pkg::CFG_MODE: begin
            pred_mode = lvlm_pkg::meter_mode_t'(cfg_data[0]);
          end
          lvlm_pkg::CFG_WINDOW: begin
            pred_window = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        predict_level(in_sample);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always begin
    @(posedge clk);
    if (calm) begin
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
          out_ready <= 1'b1;
        end
        2: begin
          out_ready <= 1'b1;
          repeat ($urandom_range(20, 100)) @(posedge clk);
        end
        default: begin
          out_ready <= 1'b1;
        end
      endcase
    end
  end

  task automatic send_sample(input logic signed [lvlm_pkg::SAMPLE_BITS-1:0] s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input lvlm_pkg::cfg_idx_t idx,
                           input logic [lvlm_pkg::LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_sample(16'sd0);
    send_sample(MOST_POS);
    send_sample(MOST_NEG);
  endtask

  task automatic test_shortened_window();
    settle();
    write_reg(lvlm_pkg::CFG_WINDOW, lvlm_pkg::LEN_W'(2));
    send_sample(16'sd1234);
  endtask

  task automatic test_extremes();
    settle();
    write_reg(lvlm_pkg::CFG_WINDOW, lvlm_pkg::LEN_W'(1));
    send_sample(MOST_NEG);
    send_sample(MOST_POS);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    settle();
    write_reg(lvlm_pkg::CFG_MODE, lvlm_pkg::LEN_W'(lvlm_pkg::MODE_PEAK));
    send_sample(MOST_NEG);
    send_sample(MOST_POS);
    send_sample(16'hFFFF);
  endtask

  task automatic test_zero_window();
    settle();
    write_reg(lvlm_pkg::CFG_WINDOW, '0);
    send_sample(16'h1234);
    send_sample(MOST_NEG);
  endtask

  task automatic test_mode_change();
    settle();
    write_reg(lvlm_pkg::CFG_WINDOW, lvlm_pkg::LEN_W'(4));
    send_sample(16'h0100);
    send_sample(16'h8001);
    settle();
    write_reg(lvlm_pkg::CFG_MODE, lvlm_pkg::LEN_W'(lvlm_pkg::MODE_RMS));
    send_sample(16'h7000);
    send_sample(16'sd0);
    send_sample(16'h0F00);
    send_sample(16'hC000);
    settle();
    write_reg(lvlm_pkg::CFG_MODE, lvlm_pkg::LEN_W'(lvlm_pkg::MODE_PEAK));
    send_sample(16'h0042);
    send_sample(16'hFF00);
  endtask

  task automatic test_saturated_window();
    settle();
    write_reg(lvlm_pkg::CFG_MODE, lvlm_pkg::LEN_W'(lvlm_pkg::MODE_RMS));
    write_reg(lvlm_pkg::CFG_WINDOW, lvlm_pkg::LEN_W'(8191));
    repeat (100) send_sample(MOST_NEG);
    settle();
    write_reg(lvlm_pkg::CFG_WINDOW, lvlm_pkg::LEN_W'(1));
    send_sample(MOST_NEG);
  endtask

  task automatic test_random();
    int                                      sent;
    int                                      burst;
    logic [lvlm_pkg::LEN_W-1:0]              span;
    logic signed [lvlm_pkg::SAMPLE_BITS-1:0] s;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (!calm) begin
        settle();
        if ($urandom_range(0, 2) == 0) begin
          write_reg(lvlm_pkg::CFG_MODE, lvlm_pkg::LEN_W'($urandom_range(0, 8191)));
        end
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 11))
            0:       span = '0;
            1:       span = lvlm_pkg::LEN_W'(1);
            2:       span = lvlm_pkg::LEN_W'($urandom_range(4097, 8191));
            3:       span = lvlm_pkg::LEN_W'(lvlm_pkg::WINDOW_MAX);
            4:       span = lvlm_pkg::LEN_W'($urandom_range(41, 300));
            5, 6:    span = lvlm_pkg::LEN_W'($urandom_range(9, 40));
            default: span = lvlm_pkg::LEN_W'($urandom_range(1, 8));
          endcase
          write_reg(lvlm_pkg::CFG_WINDOW, span);
        end
      end
      burst = $urandom_range(1, 60);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0:       s = MOST_NEG;
          1:       s = MOST_POS;
          2:       s = 16'sd0;
          3:       s = lvlm_pkg::SAMPLE_BITS'($urandom_range(0, 15)) - 16'sd8;
          4:       s = ($urandom_range(0, 1) == 1) ? MOST_NEG + 16'sd1 : MOST_POS - 16'sd1;
          default: s = lvlm_pkg::SAMPLE_BITS'($urandom());
        endcase
        send_sample(s);
        sent++;
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
          calm = 1'b1;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_shortened_window();
    test_extremes();
    test_zero_window();
    test_mode_change();
    test_saturated_window();
    test_random();
    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
